### rtl/core/sslex_pkg.sv
// shared types, codes and the syntax transition table of the statement lexer
package sslex_pkg;

	localparam int STATE_W = 4;
	localparam int CLASS_W = 3;
	localparam int LIMIT_W = 4;
	localparam int OUT_CNT_W = 8;
	localparam int CFG_IDX_W = 2;

	// syntax state codes
	localparam logic [STATE_W-1:0] ST_START         = 4'd0;
	localparam logic [STATE_W-1:0] ST_ENTER_OPCODE  = 4'd1;
	localparam logic [STATE_W-1:0] ST_OPCODE        = 4'd2;
	localparam logic [STATE_W-1:0] ST_END_OPCODE    = 4'd3;
	localparam logic [STATE_W-1:0] ST_ENTER_OPERAND = 4'd4;
	localparam logic [STATE_W-1:0] ST_OPERAND       = 4'd5;
	localparam logic [STATE_W-1:0] ST_END_OPERAND   = 4'd6;
	localparam logic [STATE_W-1:0] ST_END_STMT      = 4'd7;
	localparam logic [STATE_W-1:0] ST_DONE          = 4'd8;
	localparam logic [STATE_W-1:0] ST_ERROR         = 4'd9;
	localparam int NUM_STATES = 10;
	localparam int NUM_CLASSES = 8;

	// character class codes
	localparam logic [CLASS_W-1:0] CL_OPEN    = 3'd0;
	localparam logic [CLASS_W-1:0] CL_CLOSE   = 3'd1;
	localparam logic [CLASS_W-1:0] CL_COMMA   = 3'd2;
	localparam logic [CLASS_W-1:0] CL_ALPHA   = 3'd3;
	localparam logic [CLASS_W-1:0] CL_DIGIT   = 3'd4;
	localparam logic [CLASS_W-1:0] CL_SPACE   = 3'd5;
	localparam logic [CLASS_W-1:0] CL_EOL     = 3'd6;
	localparam logic [CLASS_W-1:0] CL_ILLEGAL = 3'd7;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_OPEN  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_CLOSE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_COMMA = 2'd2;

	localparam logic [LIMIT_W-1:0] MAX_OPEN_RST  = 4'd1;
	localparam logic [LIMIT_W-1:0] MAX_CLOSE_RST = 4'd1;
	localparam logic [LIMIT_W-1:0] MAX_COMMA_RST = 4'd2;

	// characters of interest
	localparam logic [7:0] CH_LOWER_X = 8'h78;
	localparam logic [7:0] CH_UPPER_X = 8'h58;
	localparam logic [7:0] CH_COMMA   = 8'h2c;
	localparam logic [7:0] CH_OPEN    = 8'h7b;
	localparam logic [7:0] CH_CLOSE   = 8'h7d;
	localparam logic [7:0] CH_TAB     = 8'h09;
	localparam logic [7:0] CH_LF      = 8'h0a;
	localparam logic [7:0] CH_CR      = 8'h0d;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_F = 8'h46;
	localparam logic [7:0] CH_UPPER_Z = 8'h5a;
	localparam logic [7:0] CH_LOWER_A = 8'h61;
	localparam logic [7:0] CH_LOWER_F = 8'h66;
	localparam logic [7:0] CH_LOWER_Z = 8'h7a;
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_NINE    = 8'h39;

	// rows: state, columns: class
	localparam logic [STATE_W-1:0] NEXT_TAB [NUM_STATES][NUM_CLASSES] = '{
		'{4'd1, 4'd9, 4'd4, 4'd2, 4'd5, 4'd0, 4'd8, 4'd9},
		'{4'd1, 4'd7, 4'd4, 4'd2, 4'd5, 4'd1, 4'd9, 4'd9},
		'{4'd9, 4'd7, 4'd4, 4'd2, 4'd5, 4'd3, 4'd9, 4'd9},
		'{4'd9, 4'd7, 4'd4, 4'd9, 4'd5, 4'd3, 4'd9, 4'd9},
		'{4'd9, 4'd7, 4'd8, 4'd9, 4'd5, 4'd4, 4'd9, 4'd9},
		'{4'd9, 4'd7, 4'd8, 4'd9, 4'd5, 4'd6, 4'd9, 4'd9},
		'{4'd9, 4'd7, 4'd8, 4'd9, 4'd9, 4'd6, 4'd9, 4'd9},
		'{4'd9, 4'd7, 4'd8, 4'd9, 4'd9, 4'd7, 4'd8, 4'd9},
		'{4'd9, 4'd9, 4'd8, 4'd9, 4'd9, 4'd8, 4'd8, 4'd9},
		'{4'd9, 4'd9, 4'd9, 4'd9, 4'd9, 4'd9, 4'd9, 4'd9}
	};

	typedef struct packed {
		logic [CLASS_W-1:0] cls;
		logic [STATE_W-1:0] nxt;
	} decode_t;

endpackage

### rtl/core/sslex_decode.sv
// character classifier and syntax state transition lookup
module sslex_decode (
	input  logic [7:0]                     char_in,
	input  logic [sslex_pkg::STATE_W-1:0]  state,
	output sslex_pkg::decode_t             dec
);
	import sslex_pkg::*;

	logic               upper;
	logic               lower;
	logic               hex_letter;
	logic               operand_st;
	logic [STATE_W-1:0] st;
	logic [CLASS_W-1:0] cls;

	assign upper = (char_in >= CH_UPPER_A) && (char_in <= CH_UPPER_Z);
	assign lower = (char_in >= CH_LOWER_A) && (char_in <= CH_LOWER_Z);
	assign hex_letter = ((char_in >= CH_LOWER_A) && (char_in <= CH_LOWER_F))
		|| ((char_in >= CH_UPPER_A) && (char_in <= CH_UPPER_F))
		|| (char_in == CH_LOWER_X) || (char_in == CH_UPPER_X);

	// out of range codes behave as the error state
	assign st = (state > ST_ERROR) ? ST_ERROR : state;
	assign operand_st = (st >= ST_ENTER_OPERAND) && (st <= ST_END_OPERAND);

	always_comb begin
		priority if (upper || lower) begin
			cls = (operand_st && hex_letter) ? CL_DIGIT : CL_ALPHA;
		end else if ((char_in >= CH_ZERO) && (char_in <= CH_NINE)) begin
			cls = CL_DIGIT;
		end else if ((char_in == CH_SPACE) || (char_in == CH_TAB)) begin
			cls = CL_SPACE;
		end else if ((char_in == CH_LF) || (char_in == CH_CR)) begin
			cls = CL_EOL;
		end else if (char_in == CH_OPEN) begin
			cls = CL_OPEN;
		end else if (char_in == CH_CLOSE) begin
			cls = CL_CLOSE;
		end else if (char_in == CH_COMMA) begin
			cls = CL_COMMA;
		end else begin
			cls = CL_ILLEGAL;
		end
	end

	assign dec.cls = cls;
	assign dec.nxt = NEXT_TAB[st][cls];

endmodule

### rtl/core/statement_syntax_lexer.sv
// statement syntax lexer top level: input stage, counters and result stage
//
// One source byte enters per transaction on the input channel (char_in,
// restart; in_valid / in_stall). Each accepted byte gives exactly one result
// on the output channel (next_state, char_class and five counters;
// out_valid / out_stall). restart clears the syntax state and all counters
// before its own byte is processed.
// The result of an accepted byte passes the input register, then one
// combinational step into the result register.
// Throughput: one byte per cycle while the receiver does not stall; the syntax
// state and counters close a loop through the classifier and transition table.
// When the receiver stalls, the result register holds; the input register
// still takes one more byte, and in_stall rises only when both are full.
// The limit registers are written over cfg_valid / cfg_ready (always ready)
// with cfg_index 0..2; index 3 is ignored. Writes are meant while idle.
// Reset (arst_n low) clears the state, counters and both valid flags and
// loads limits 1, 1 and 2. Counters are COUNT_WIDTH bits and saturate;
// the low eight bits are reported.
module statement_syntax_lexer #(
	parameter int COUNT_WIDTH = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [7:0]                        char_in,
	input  logic                              restart,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [sslex_pkg::STATE_W-1:0]     next_state,
	output logic [sslex_pkg::CLASS_W-1:0]     char_class,
	output logic [sslex_pkg::OUT_CNT_W-1:0]   open_brace_count,
	output logic [sslex_pkg::OUT_CNT_W-1:0]   close_brace_count,
	output logic [sslex_pkg::OUT_CNT_W-1:0]   comma_count,
	output logic [sslex_pkg::OUT_CNT_W-1:0]   multi_statement_count,
	output logic [sslex_pkg::OUT_CNT_W-1:0]   illegal_first_count,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [sslex_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [sslex_pkg::LIMIT_W-1:0]     cfg_data
);
	import sslex_pkg::*;

	localparam int CW = COUNT_WIDTH;
	localparam int EXT_W = CW + OUT_CNT_W;

	logic [LIMIT_W-1:0] max_open_q, max_close_q, max_comma_q;

	logic               valid_s1;
	logic [7:0]         char_s1;
	logic               restart_s1;

	logic [STATE_W-1:0] state_q;
	logic [CW-1:0]      open_q, close_q, comma_q, multi_q, illegal_q;

	logic               valid_s2;
	logic [STATE_W-1:0] next_state_s2;
	logic [CLASS_W-1:0] class_s2;
	logic [CW-1:0]      open_s2, close_s2, comma_s2, multi_s2, illegal_s2;

	logic               advance;
	logic               step;
	logic [STATE_W-1:0] state_base;
	logic [CW-1:0]      open_base, close_base, comma_base, multi_base, illegal_base;
	logic [CW-1:0]      open_nx, close_nx, comma_nx, multi_nx, illegal_nx;
	logic               over_limit;
	decode_t            dec;

	function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] v);
		return (v == {CW{1'b1}}) ? v : v + 1'b1;
	endfunction

	function automatic logic [OUT_CNT_W-1:0] low_bits(input logic [CW-1:0] v);
		logic [EXT_W-1:0] ext;
		ext = EXT_W'(v);
		return ext[OUT_CNT_W-1:0];
	endfunction

	function automatic logic above(input logic [CW-1:0] cnt, input logic [LIMIT_W-1:0] lim);
		logic [EXT_W-1:0] c_ext;
		logic [EXT_W-1:0] l_ext;
		c_ext = EXT_W'(cnt);
		l_ext = EXT_W'(lim);
		return c_ext > l_ext;
	endfunction

	// configuration
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_open_q  <= MAX_OPEN_RST;
			max_close_q <= MAX_CLOSE_RST;
			max_comma_q <= MAX_COMMA_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_MAX_OPEN:  max_open_q  <= cfg_data;
				CFG_MAX_CLOSE: max_close_q <= cfg_data;
				CFG_MAX_COMMA: max_comma_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// pipeline control
	assign advance  = !(valid_s2 && out_stall);
	assign in_stall = valid_s1 && !advance;
	assign step     = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			char_s1    <= char_in;
			restart_s1 <= restart;
		end
	end

	// restart clears everything before the byte is looked at
	assign state_base   = restart_s1 ? ST_START : state_q;
	assign open_base    = restart_s1 ? '0 : open_q;
	assign close_base   = restart_s1 ? '0 : close_q;
	assign comma_base   = restart_s1 ? '0 : comma_q;
	assign multi_base   = restart_s1 ? '0 : multi_q;
	assign illegal_base = restart_s1 ? '0 : illegal_q;

	sslex_decode u_decode (
		.char_in (char_s1),
		.state   (state_base),
		.dec     (dec)
	);

	always_comb begin
		open_nx    = open_base;
		close_nx   = close_base;
		comma_nx   = comma_base;
		over_limit = 1'b0;
		unique case (dec.cls)
			CL_OPEN: begin
				open_nx    = sat_inc(open_base);
				over_limit = above(open_nx, max_open_q);
			end
			CL_CLOSE: begin
				close_nx   = sat_inc(close_base);
				over_limit = above(close_nx, max_close_q);
			end
			CL_COMMA: begin
				comma_nx   = sat_inc(comma_base);
				over_limit = above(comma_nx, max_comma_q);
			end
			default: ;
		endcase
		multi_nx = over_limit ? sat_inc(multi_base) : multi_base;
		illegal_nx = ((state_base == ST_START) && (dec.cls != CL_SPACE)
			&& (dec.cls != CL_EOL) && (dec.cls != CL_OPEN))
			? sat_inc(illegal_base) : illegal_base;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_START;
			open_q    <= '0;
			close_q   <= '0;
			comma_q   <= '0;
			multi_q   <= '0;
			illegal_q <= '0;
		end else if (step) begin
			state_q   <= dec.nxt;
			open_q    <= open_nx;
			close_q   <= close_nx;
			comma_q   <= comma_nx;
			multi_q   <= multi_nx;
			illegal_q <= illegal_nx;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			next_state_s2 <= dec.nxt;
			class_s2      <= dec.cls;
			open_s2       <= open_nx;
			close_s2      <= close_nx;
			comma_s2      <= comma_nx;
			multi_s2      <= multi_nx;
			illegal_s2    <= illegal_nx;
		end
	end

	assign out_valid             = valid_s2;
	assign next_state            = next_state_s2;
	assign char_class            = class_s2;
	assign open_brace_count      = low_bits(open_s2);
	assign close_brace_count     = low_bits(close_s2);
	assign comma_count           = low_bits(comma_s2);
	assign multi_statement_count = low_bits(multi_s2);
	assign illegal_first_count   = low_bits(illegal_s2);

	a_state_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q <= ST_ERROR)
		else $error("syntax state out of range");

	a_error_absorbs: assert property (@(posedge clk) disable iff (!arst_n)
		step && !restart_s1 && (state_q == ST_ERROR) |=> next_state == ST_ERROR)
		else $error("error state left without restart");

	a_restart_open: assert property (@(posedge clk) disable iff (!arst_n)
		step && restart_s1 |=> open_q <= CW'(1))
		else $error("open brace count not cleared by restart");

	a_counts_grow: assert property (@(posedge clk) disable iff (!arst_n)
		step && !restart_s1 |=> (open_q >= $past(open_q))
			&& (multi_q >= $past(multi_q)) && (illegal_q >= $past(illegal_q)))
		else $error("counter decreased without restart");

	a_result_matches_state: assert property (@(posedge clk) disable iff (!arst_n)
		step |=> next_state_s2 == state_q)
		else $error("result state differs from stored state");

endmodule

### tb/tb_top.sv
// self-checking testbench for the statement syntax lexer: byte stream in, lexer results out
module tb_top;
	import sslex_pkg::*;

	localparam int CLK_PERIOD = 10;
	localparam int CNT_W = 8;
	localparam int IDLE_MAX = 9;
	localparam int HOLD_CYCLES = 60;
	localparam int DRAIN_CYCLES = 6;
	localparam int STMT_BYTES = 110;
	localparam int FLOOD_LEN = 262;
	localparam int NUM_PHASES = 8;
	localparam int TIMEOUT_CYCLES = 400000;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
	localparam logic [LIMIT_W-1:0] LIMIT_TOP = '1;

	// next syntax state, rows by current state, columns by character class
	localparam logic [STATE_W-1:0] SYNTAX_NEXT [NUM_STATES][NUM_CLASSES] = '{
		'{ST_ENTER_OPCODE, ST_ERROR, ST_ENTER_OPERAND, ST_OPCODE,
		  ST_OPERAND, ST_START, ST_DONE, ST_ERROR},
		'{ST_ENTER_OPCODE, ST_END_STMT, ST_ENTER_OPERAND, ST_OPCODE,
		  ST_OPERAND, ST_ENTER_OPCODE, ST_ERROR, ST_ERROR},
		'{ST_ERROR, ST_END_STMT, ST_ENTER_OPERAND, ST_OPCODE,
		  ST_OPERAND, ST_END_OPCODE, ST_ERROR, ST_ERROR},
		'{ST_ERROR, ST_END_STMT, ST_ENTER_OPERAND, ST_ERROR,
		  ST_OPERAND, ST_END_OPCODE, ST_ERROR, ST_ERROR},
		'{ST_ERROR, ST_END_STMT, ST_DONE, ST_ERROR,
		  ST_OPERAND, ST_ENTER_OPERAND, ST_ERROR, ST_ERROR},
		'{ST_ERROR, ST_END_STMT, ST_DONE, ST_ERROR,
		  ST_OPERAND, ST_END_OPERAND, ST_ERROR, ST_ERROR},
		'{ST_ERROR, ST_END_STMT, ST_DONE, ST_ERROR,
		  ST_ERROR, ST_END_OPERAND, ST_ERROR, ST_ERROR},
		'{ST_ERROR, ST_END_STMT, ST_DONE, ST_ERROR,
		  ST_ERROR, ST_END_STMT, ST_DONE, ST_ERROR},
		'{ST_ERROR, ST_ERROR, ST_DONE, ST_ERROR,
		  ST_ERROR, ST_DONE, ST_DONE, ST_ERROR},
		'{ST_ERROR, ST_ERROR, ST_ERROR, ST_ERROR,
		  ST_ERROR, ST_ERROR, ST_ERROR, ST_ERROR}
	};

	typedef struct packed {
		logic [7:0] ch;
		logic       rs;
	} source_byte_t;

	typedef struct packed {
		logic [STATE_W-1:0]   nxt;
		logic [CLASS_W-1:0]   cls;
		logic [OUT_CNT_W-1:0] opens;
		logic [OUT_CNT_W-1:0] closes;
		logic [OUT_CNT_W-1:0] commas;
		logic [OUT_CNT_W-1:0] multi;
		logic [OUT_CNT_W-1:0] first_err;
	} lex_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [7:0] char_in = 8'h00;
	logic restart = 1'b0;
	logic out_valid;
	logic out_stall;
	logic [STATE_W-1:0] next_state;
	logic [CLASS_W-1:0] char_class;
	logic [OUT_CNT_W-1:0] open_brace_count;
	logic [OUT_CNT_W-1:0] close_brace_count;
	logic [OUT_CNT_W-1:0] comma_count;
	logic [OUT_CNT_W-1:0] multi_statement_count;
	logic [OUT_CNT_W-1:0] illegal_first_count;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_MAX_OPEN;
	logic [LIMIT_W-1:0] cfg_data = '0;

	// predictor state
	logic [STATE_W-1:0] syn_state = ST_START;
	logic [CNT_W-1:0] n_open = '0;
	logic [CNT_W-1:0] n_close = '0;
	logic [CNT_W-1:0] n_comma = '0;
	logic [CNT_W-1:0] n_multi = '0;
	logic [CNT_W-1:0] n_first = '0;
	logic [LIMIT_W-1:0] lim_open = MAX_OPEN_RST;
	logic [LIMIT_W-1:0] lim_close = MAX_CLOSE_RST;
	logic [LIMIT_W-1:0] lim_comma = MAX_COMMA_RST;

	source_byte_t source_bytes[$];
	lex_result_t predicted_lex[$];

	int tx_idle_max = IDLE_MAX;
	int rx_idle_max = IDLE_MAX;
	int tx_gap = 0;
	int rx_wait = 0;
	logic rx_pause = 1'b0;
	logic rx_hold_on = 1'b0;
	int hold_left = 0;
	int holds_asked = 0;
	int holds_done = 0;
	int bytes_queued = 0;
	int bytes_in = 0;
	int results_seen = 0;
	int statements = 0;
	int settings_used = 1;
	int mismatches = 0;

	assign out_stall = rx_pause | rx_hold_on;

	statement_syntax_lexer #(
		.COUNT_WIDTH(CNT_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.char_in(char_in),
		.restart(restart),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.next_state(next_state),
		.char_class(char_class),
		.open_brace_count(open_brace_count),
		.close_brace_count(close_brace_count),
		.comma_count(comma_count),
		.multi_statement_count(multi_statement_count),
		.illegal_first_count(illegal_first_count),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] v);
		return (v == '1) ? v : v + 1'b1;
	endfunction

	function automatic logic [CLASS_W-1:0] class_of(input logic [7:0] ch,
			input logic [STATE_W-1:0] st);
		logic upper, lower, hex, operand_ctx;
		upper = (ch >= CH_UPPER_A && ch <= CH_UPPER_Z);
		lower = (ch >= CH_LOWER_A && ch <= CH_LOWER_Z);
		hex = (ch >= CH_UPPER_A && ch <= CH_UPPER_F) || (ch >= CH_LOWER_A && ch <= CH_LOWER_F)
			|| ch == CH_LOWER_X || ch == CH_UPPER_X;
		operand_ctx = (st >= ST_ENTER_OPERAND && st <= ST_END_OPERAND);
		if (upper || lower)
			return (hex && operand_ctx) ? CL_DIGIT : CL_ALPHA;
		if (ch >= CH_ZERO && ch <= CH_NINE)
			return CL_DIGIT;
		if (ch == CH_SPACE || ch == CH_TAB)
			return CL_SPACE;
		if (ch == CH_LF || ch == CH_CR)
			return CL_EOL;
		if (ch == CH_OPEN)
			return CL_OPEN;
		if (ch == CH_CLOSE)
			return CL_CLOSE;
		if (ch == CH_COMMA)
			return CL_COMMA;
		return CL_ILLEGAL;
	endfunction

	function automatic lex_result_t advance_lexer(input logic [7:0] ch, input logic rs);
		lex_result_t r;
		logic [STATE_W-1:0] st;
		logic [CLASS_W-1:0] cls;
		if (rs) begin
			syn_state = ST_START;
			n_open = '0;
			n_close = '0;
			n_comma = '0;
			n_multi = '0;
			n_first = '0;
		end
		st = syn_state;
		cls = class_of(ch, st);
		// limit test runs on the count after its increment, saturated or not
		case (cls)
			CL_OPEN: begin
				n_open = bump(n_open);
				if (n_open > lim_open)
					n_multi = bump(n_multi);
			end
			CL_CLOSE: begin
				n_close = bump(n_close);
				if (n_close > lim_close)
					n_multi = bump(n_multi);
			end
			CL_COMMA: begin
				n_comma = bump(n_comma);
				if (n_comma > lim_comma)
					n_multi = bump(n_multi);
			end
			default: ;
		endcase
		if (st == ST_START && cls != CL_SPACE && cls != CL_EOL && cls != CL_OPEN)
			n_first = bump(n_first);
		syn_state = SYNTAX_NEXT[st][cls];
		r.nxt = syn_state;
		r.cls = cls;
		r.opens = n_open[OUT_CNT_W-1:0];
		r.closes = n_close[OUT_CNT_W-1:0];
		r.commas = n_comma[OUT_CNT_W-1:0];
		r.multi = n_multi[OUT_CNT_W-1:0];
		r.first_err = n_first[OUT_CNT_W-1:0];
		return r;
	endfunction

	task automatic check_field(input string name, input logic [7:0] exp_v,
			input logic [7:0] act_v);
		if (act_v !== exp_v) begin
			$error("%s: expected %0d, actual %0d", name, exp_v, act_v);
			mismatches++;
		end
	endtask

	// sender: holds a stalled byte, otherwise waits out its gap and offers the next one
	always @(posedge clk or negedge arst_n) begin
		source_byte_t nb;
		if (!arst_n) begin
			in_valid <= 1'b0;
			tx_gap <= 0;
		end else begin
			if (in_valid && !in_stall) begin
				predicted_lex.push_back(advance_lexer(char_in, restart));
				bytes_in++;
			end
			if (!(in_valid && in_stall)) begin
				if (tx_gap != 0) begin
					tx_gap <= tx_gap - 1;
					in_valid <= 1'b0;
				end else if (source_bytes.size() != 0) begin
					nb = source_bytes.pop_front();
					in_valid <= 1'b1;
					char_in <= nb.ch;
					restart <= nb.rs;
					tx_gap <= $urandom_range(0, tx_idle_max);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver: checks each result transaction, then may stall for a random pause
	always @(posedge clk or negedge arst_n) begin
		lex_result_t want;
		int w;
		if (!arst_n) begin
			rx_pause <= 1'b0;
			rx_wait <= 0;
		end else if (out_valid && !out_stall) begin
			results_seen++;
			if (predicted_lex.size() == 0) begin
				$error("result with no byte outstanding: next_state %0d", next_state);
				mismatches++;
			end else begin
				want = predicted_lex.pop_front();
				check_field("next_state", 8'(want.nxt), 8'(next_state));
				check_field("char_class", 8'(want.cls), 8'(char_class));
				check_field("open_brace_count", want.opens, open_brace_count);
				check_field("close_brace_count", want.closes, close_brace_count);
				check_field("comma_count", want.commas, comma_count);
				check_field("multi_statement_count", want.multi, multi_statement_count);
				check_field("illegal_first_count", want.first_err, illegal_first_count);
			end
			w = $urandom_range(0, rx_idle_max);
			rx_wait <= w;
			rx_pause <= (w != 0);
		end else if (rx_wait != 0) begin
			rx_wait <= rx_wait - 1;
			rx_pause <= (rx_wait > 1);
		end
	end

	// long receiver hold-off, started once a result is waiting so the pipe backs up
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			holds_done <= 0;
			rx_hold_on <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			rx_hold_on <= (hold_left > 1);
		end else if (holds_done != holds_asked && out_valid) begin
			hold_left <= HOLD_CYCLES;
			rx_hold_on <= 1'b1;
			holds_done <= holds_done + 1;
		end
	end

	task automatic push_byte(input logic [7:0] ch, input logic rs);
		source_byte_t b;
		b.ch = ch;
		b.rs = rs;
		source_bytes.push_back(b);
		bytes_queued++;
	endtask

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++)
			push_byte(s[i], i == 0);
	endtask

	function automatic logic [7:0] pick_space();
		return $urandom_range(0, 1) ? CH_SPACE : CH_TAB;
	endfunction

	function automatic logic [7:0] pick_letter();
		return ($urandom_range(0, 1) ? CH_UPPER_A : CH_LOWER_A) + 8'($urandom_range(0, 25));
	endfunction

	// mostly "{ opcode , operand }" lines with random content; some truncated,
	// some with a corrupted byte, some pure noise
	task automatic push_statement();
		logic [7:0] text[$];
		string digit_chars;
		int kind, cut;
		logic rs_first;
		digit_chars = "0123456789abcdefABCDEFxX";
		kind = $urandom_range(0, 9);
		rs_first = ($urandom_range(0, 9) != 0);
		if (kind == 0) begin
			repeat ($urandom_range(1, 6)) text.push_back(8'($urandom_range(0, 255)));
		end else begin
			repeat ($urandom_range(0, 2)) text.push_back(pick_space());
			if ($urandom_range(0, 7) != 0)
				text.push_back(CH_OPEN);
			repeat ($urandom_range(0, 1)) text.push_back(pick_space());
			repeat ($urandom_range(1, 4)) text.push_back(pick_letter());
			repeat ($urandom_range(0, 2)) text.push_back(pick_space());
			repeat ($urandom_range(0, 2)) begin
				text.push_back(CH_COMMA);
				repeat ($urandom_range(0, 1)) text.push_back(pick_space());
				repeat ($urandom_range(1, 4))
					text.push_back(digit_chars[$urandom_range(0, digit_chars.len() - 1)]);
				repeat ($urandom_range(0, 1)) text.push_back(pick_space());
			end
			if ($urandom_range(0, 5) != 0)
				text.push_back(CH_CLOSE);
			repeat ($urandom_range(0, 1)) text.push_back(pick_space());
			if ($urandom_range(0, 3) != 0)
				text.push_back($urandom_range(0, 1) ? CH_LF : CH_CR);
			if (kind == 1) begin
				cut = $urandom_range(1, text.size());
				while (text.size() > cut)
					void'(text.pop_back());
			end else if (kind == 2) begin
				text[$urandom_range(0, text.size() - 1)] = 8'($urandom_range(0, 255));
			end
		end
		foreach (text[i])
			push_byte(text[i], (i == 0) ? rs_first : ($urandom_range(0, 49) == 0));
		statements++;
	endtask

	task automatic program_limit(input logic [CFG_IDX_W-1:0] idx, input logic [LIMIT_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_MAX_OPEN: lim_open = val;
			CFG_MAX_CLOSE: lim_close = val;
			CFG_MAX_COMMA: lim_comma = val;
			default: ;
		endcase
	endtask

	// sender stays quiet until every outstanding result is back
	task automatic wait_drained();
		while (source_bytes.size() != 0 || in_valid || predicted_lex.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	initial begin
		logic [LIMIT_W-1:0] lo, lc, lm;
		logic [7:0] flood_ch;
		int phase_base;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: a clean statement with hex operand, bad first characters,
		// punctuation over the reset limits, byte extremes and illegal controls
		push_text("{m\t,xF0 }\r");
		push_text("Q");
		push_byte(8'hff, 1'b0);
		push_text(" \n");
		push_byte(8'h00, 1'b1);
		push_text("}},,,");
		push_text("{{");
		push_byte(8'h0b, 1'b0);
		push_byte(8'h80, 1'b0);
		push_text("{ ,Eg");
		wait_drained();

		for (int p = 0; p < NUM_PHASES; p++) begin
			lo = LIMIT_W'($urandom_range(0, 15));
			lc = LIMIT_W'($urandom_range(0, 15));
			lm = LIMIT_W'($urandom_range(0, 15));
			case (p)
				0: begin
					lo = '0;
					lc = '0;
					lm = '0;
				end
				1: begin
					lo = LIMIT_TOP;
					lc = LIMIT_TOP;
					lm = LIMIT_TOP;
				end
				4: begin
					lo = '0;
					lc = LIMIT_TOP;
					lm = '0;
				end
				6: begin
					lo = LIMIT_TOP;
					lc = '0;
					lm = LIMIT_TOP;
				end
				default: ;
			endcase
			if (p == NUM_PHASES - 1)
				program_limit(CFG_UNUSED, LIMIT_W'($urandom_range(0, 15)));
			program_limit(CFG_MAX_OPEN, lo);
			program_limit(CFG_MAX_CLOSE, lc);
			program_limit(CFG_MAX_COMMA, lm);
			settings_used++;
			@(negedge clk);
			tx_idle_max = (p == 3 || p == 5) ? 0 : IDLE_MAX;
			rx_idle_max = (p == 5) ? 0 : IDLE_MAX;
			if (p == 3)
				holds_asked++;
			phase_base = bytes_queued;
			while (bytes_queued - phase_base < STMT_BYTES)
				push_statement();
			// one long run of a single punctuation mark drives its counter into saturation
			if (p < 3) begin
				flood_ch = (p == 0) ? CH_OPEN : (p == 1) ? CH_COMMA : CH_CLOSE;
				push_byte(flood_ch, 1'b1);
				repeat (FLOOD_LEN - 1) push_byte(flood_ch, 1'b0);
			end
			wait_drained();
		end

		$display("%0d bytes in %0d statements over %0d limit settings, with saturating runs",
			bytes_in, statements, settings_used);
		$display("%0d results checked, %0d mismatches, %0d long receiver hold-offs",
			results_seen, mismatches, holds_done);
		if (mismatches == 0 && predicted_lex.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin
		#(TIMEOUT_CYCLES * CLK_PERIOD);
		$display("Verification failed");
		$finish;
	end

endmodule
